>>> src/clow_pkg.sv
`default_nettype none
package clow_pkg;
  localparam int NUM_MARKERS = 1024;
  localparam int LOG_DEPTH   = 64;
  localparam int NUM_THREADS = 8;
  localparam int MW = $clog2(NUM_MARKERS);
  localparam int RW = $clog2(LOG_DEPTH);
  localparam int TW = $clog2(NUM_THREADS);
  localparam int CW = RW + 1;
  localparam int LW = 42;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_NEW            = 3'd0,
    ST_SAME           = 3'd1,
    ST_ALIAS_FOUND    = 3'd2,
    ST_ALIAS_APPENDED = 3'd3,
    ST_CONFLICT       = 3'd4,
    ST_FULL           = 3'd5,
    ST_DONE           = 3'd6
  } status_t;

  // marker entry: used, owner, record
  typedef struct packed {
    logic          used;
    logic [2:0]    owner;
    logic [RW-1:0] rec;
  } marker_t;

  typedef struct packed {
    logic          we;
    logic [MW-1:0] addr;
    marker_t       wdata;
  } mk_req_t;

  typedef struct packed {
    logic              we;
    logic [TW+RW-1:0]  addr;
    logic [LW-1:0]     wdata;
  } lg_req_t;
endpackage
`default_nettype wire

>>> src/clow_if.sv
`default_nettype none
interface clow_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [47:0] byte_address;
  logic [2:0]  thread_id;
  modport source (output valid, mode, byte_address, thread_id, input ready);
  modport sink (input valid, mode, byte_address, thread_id, output ready);
endinterface

interface clow_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] record_index;
  modport source (output valid, status, record_index, input ready);
  modport sink (input valid, status, record_index, output ready);
endinterface
`default_nettype wire

>>> src/clow_marker_mem.sv
`default_nettype none
module clow_marker_mem (
  input  wire logic             clk,
  input  wire clow_pkg::mk_req_t req,
  output clow_pkg::marker_t     rdata
);
  import clow_pkg::*;
  // valid bits stand for used; clearing pass is done by the controller
  marker_t mem [NUM_MARKERS];
  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    rdata <= mem[req.addr];
  end
endmodule
`default_nettype wire

>>> src/clow_log_mem.sv
`default_nettype none
module clow_log_mem (
  input  wire logic              clk,
  input  wire clow_pkg::lg_req_t req,
  output logic [clow_pkg::LW-1:0] rdata
);
  import clow_pkg::*;
  logic [LW-1:0] mem [NUM_THREADS*LOG_DEPTH];
  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    rdata <= mem[req.addr];
  end
endmodule
`default_nettype wire

>>> src/cache_line_ownership_write_log_unit.sv
`default_nettype none
// Flow: release (marker freed on accept), unused mode and bad thread go straight to the result;
// a write reads and checks the marker, on a same-thread hit compares the stored record, then the
// later ones, appending on a miss; a clear frees each logged line's marker; out ready low stalls.
// Throughput: one item at a time; the next is taken once the result transfers.
// Reset: after rst_n the block sweeps the marker memory, one entry a cycle,
// all NUM_MARKERS (1024) entries, accepting no item; log counts clear at once.
module cache_line_ownership_write_log_unit (
  input wire logic clk,
  input wire logic rst_n,
  clow_in_if.sink    in_ch,
  clow_out_if.source out_ch
);
  import clow_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MRD, S_MCHK, S_LCHK, S_SRCH, S_LCHK2, S_CLRD, S_CLRM, S_OUT
  } state_t;

  state_t         state_r;
  logic [MW-1:0]  init_r;
  logic [CW-1:0]  cnt_r [NUM_THREADS];
  logic [LW-1:0]  line_r;
  logic [TW-1:0]  tid_r;
  logic [CW-1:0]  size_r;
  logic [CW-1:0]  idx_r;
  logic [2:0]     status_r;
  logic [RW-1:0]  rec_r;

  mk_req_t  mk_req;
  lg_req_t  lg_req;
  marker_t  mk_rd;
  logic [LW-1:0] lg_rd;

  clow_marker_mem u_mk (.clk(clk), .req(mk_req), .rdata(mk_rd));
  clow_log_mem    u_lg (.clk(clk), .req(lg_req), .rdata(lg_rd));

  logic [LW-1:0] in_line;
  logic [MW-1:0] in_mk;
  logic          tid_ok;
  assign in_line = in_ch.byte_address[47:6];
  assign in_mk   = in_line[MW-1:0];
  assign tid_ok  = ({3'b0, in_ch.thread_id} < 6'(NUM_THREADS));
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status = status_r;
  assign out_ch.record_index = 6'(rec_r);

  logic full_c;
  assign full_c = (size_r >= CW'(LOG_DEPTH));

  // memory port requests
  always_comb begin
    mk_req = '0;
    lg_req = '0;
    unique case (state_r)
      S_INIT: begin
        mk_req.we = 1'b1;
        mk_req.addr = init_r;
      end
      S_IDLE: begin
        mk_req.addr = in_mk;
        if (in_ch.valid && tid_ok && in_ch.mode == MODE_RELEASE) mk_req.we = 1'b1;
        lg_req.addr = {in_ch.thread_id[TW-1:0], RW'(0)};
      end
      // issue the marker read that S_MCHK checks
      S_MRD: mk_req.addr = line_r[MW-1:0];
      S_MCHK: begin
        mk_req.addr = line_r[MW-1:0];
        if (!mk_rd.used) begin
          mk_req.we = 1'b1;
          mk_req.wdata = '{used: 1'b1, owner: 3'(tid_r), rec: size_r[RW-1:0]};
        end
        lg_req.addr = {tid_r, mk_rd.rec};
        if (!full_c && (!mk_rd.used)) begin
          lg_req.we = 1'b1;
          lg_req.addr = {tid_r, size_r[RW-1:0]};
          lg_req.wdata = line_r;
        end
      end
      S_SRCH: begin
        lg_req.addr = {tid_r, idx_r[RW-1:0]};
        if (idx_r >= size_r) begin
          lg_req.we = 1'b1;
          lg_req.addr = {tid_r, size_r[RW-1:0]};
          lg_req.wdata = line_r;
        end
      end
      S_CLRD: lg_req.addr = {tid_r, idx_r[RW-1:0]};
      S_CLRM: begin
        mk_req.we = 1'b1;
        mk_req.addr = lg_rd[MW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r <= '0;
      for (int t = 0; t < NUM_THREADS; t++) cnt_r[t] <= '0;
    end else begin
      unique case (state_r)
        S_INIT: begin
          init_r <= init_r + 1'b1;
          if (init_r == MW'(NUM_MARKERS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          line_r <= in_line;
          tid_r  <= in_ch.thread_id[TW-1:0];
          size_r <= cnt_r[in_ch.thread_id[TW-1:0]];
          idx_r  <= '0;
          status_r <= ST_DONE;
          rec_r <= '0;
          if (!tid_ok || in_ch.mode == MODE_RELEASE || in_ch.mode == MODE_NONE)
            state_r <= S_OUT;
          else if (in_ch.mode == MODE_WRITE) state_r <= S_MRD;
          else state_r <= S_CLRD;
        end
        S_MRD: state_r <= S_MCHK;
        S_MCHK: begin
          // claim first, then size test
          if (full_c) begin
            status_r <= ST_FULL;
            state_r <= S_OUT;
          end else if (mk_rd.used && mk_rd.owner != 3'(tid_r)) begin
            status_r <= ST_CONFLICT;
            state_r <= S_OUT;
          end else if (!mk_rd.used) begin
            status_r <= ST_NEW;
            rec_r <= size_r[RW-1:0];
            cnt_r[tid_r] <= size_r + 1'b1;
            state_r <= S_OUT;
          end else begin
            idx_r <= {1'b0, mk_rd.rec};
            rec_r <= mk_rd.rec;
            state_r <= S_LCHK;
          end
        end
        S_LCHK: begin
          // stored record compare; idx_r at or past end still compares
          if (lg_rd == line_r) begin
            status_r <= ST_SAME;
            state_r <= S_OUT;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          // issue next record read; compare result arrives on following pass
          if (idx_r >= size_r) begin
            status_r <= ST_ALIAS_APPENDED;
            rec_r <= size_r[RW-1:0];
            cnt_r[tid_r] <= size_r + 1'b1;
            state_r <= S_OUT;
          end else state_r <= S_LCHK2;
        end
        S_LCHK2: begin
          if (lg_rd == line_r) begin
            status_r <= ST_ALIAS_FOUND;
            rec_r <= idx_r[RW-1:0];
            state_r <= S_OUT;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_CLRD: begin
          if (idx_r >= size_r || idx_r >= CW'(LOG_DEPTH)) begin
            cnt_r[tid_r] <= '0;
            state_r <= S_OUT;
          end else state_r <= S_CLRM;
        end
        S_CLRM: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_CLRD;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_INIT;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
import clow_pkg::*;

// Ownership table predictor and queue of pending responses.
class ownership_scoreboard;
  logic          mk_used  [NUM_MARKERS];
  logic [2:0]    mk_owner [NUM_MARKERS];
  logic [RW-1:0] mk_rec   [NUM_MARKERS];
  logic [LW-1:0] wlog     [NUM_THREADS][LOG_DEPTH];
  int unsigned   wlog_len [NUM_THREADS];
  status_t       exp_status[$];
  logic [5:0]    exp_rec[$];
  int            errors;

  function new();
    for (int m = 0; m < NUM_MARKERS; m++) begin
      mk_used[m]  = 1'b0;
      mk_owner[m] = '0;
      mk_rec[m]   = '0;
    end
    for (int t = 0; t < NUM_THREADS; t++) begin
      wlog_len[t] = 0;
      for (int r = 0; r < LOG_DEPTH; r++) wlog[t][r] = '0;
    end
    errors = 0;
  endfunction

  function int pending();
    return exp_status.size();
  endfunction

  function void push(status_t st, int unsigned rec);
    exp_status.push_back(st);
    exp_rec.push_back(rec[5:0]);
  endfunction

  // Log write: claim first, then test the size, then the conflict, then look up the record.
  function void log_write(logic [LW-1:0] line, int unsigned tid);
    int unsigned m;
    int unsigned size;
    int unsigned rec;
    bit own_hit;
    bit conflict;
    m = line[MW-1:0];
    size = wlog_len[tid];
    own_hit = 0;
    conflict = 0;
    rec = 0;
    if (mk_used[m]) begin
      if (mk_owner[m] == tid) begin
        own_hit = 1;
        rec = mk_rec[m];
      end else begin
        conflict = 1;
      end
    end else begin
      mk_used[m]  = 1'b1;
      mk_owner[m] = tid[2:0];
      mk_rec[m]   = RW'(size % LOG_DEPTH);
    end
    if (size >= LOG_DEPTH) begin
      push(ST_FULL, 0);
      return;
    end
    if (conflict) begin
      push(ST_CONFLICT, 0);
      return;
    end
    if (!own_hit) begin
      wlog[tid][size] = line;
      wlog_len[tid] = size + 1;
      push(ST_NEW, size);
      return;
    end
    rec = rec % LOG_DEPTH;
    if (wlog[tid][rec] == line) begin
      push(ST_SAME, rec);
      return;
    end
    for (int unsigned i = rec + 1; i < size; i++) begin
      if (wlog[tid][i] == line) begin
        push(ST_ALIAS_FOUND, i);
        return;
      end
    end
    wlog[tid][size] = line;
    wlog_len[tid] = size + 1;
    push(ST_ALIAS_APPENDED, size);
  endfunction

  function void note_input(mode_t mode, logic [47:0] addr, logic [2:0] tid);
    logic [LW-1:0] line;
    int unsigned n;
    line = addr[47:6];
    if (int'(tid) >= NUM_THREADS) begin
      push(ST_DONE, 0);
      return;
    end
    case (mode)
      MODE_WRITE: log_write(line, tid);
      MODE_RELEASE: begin
        mk_used[line[MW-1:0]] = 1'b0;
        push(ST_DONE, 0);
      end
      MODE_CLEAR: begin
        n = (wlog_len[tid] > LOG_DEPTH) ? LOG_DEPTH : wlog_len[tid];
        for (int unsigned i = 0; i < n; i++) mk_used[wlog[tid][i][MW-1:0]] = 1'b0;
        wlog_len[tid] = 0;
        push(ST_DONE, 0);
      end
      default: push(ST_DONE, 0);
    endcase
  endfunction

  function void check_result(logic [2:0] status, logic [5:0] rec);
    status_t es;
    logic [5:0] er;
    if (exp_status.size() == 0) begin
      $display("%0t: unexpected response status=%0d record=%0d", $time, status, rec);
      errors++;
      return;
    end
    es = exp_status.pop_front();
    er = exp_rec.pop_front();
    if (status !== es) begin
      $display("%0t: status mismatch expected=%0d actual=%0d", $time, es, status);
      errors++;
    end
    if (rec !== er) begin
      $display("%0t: record_index mismatch expected=%0d actual=%0d", $time, er, rec);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_500_000;

  logic clk;
  logic rst_n;
  clow_in_if  in_ch();
  clow_out_if out_ch();

  ownership_scoreboard sb;
  int  cycles;
  bit  calm;       // suppress random idling on both sides

  cache_line_ownership_write_log_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    sb = new();
    cycles = 0;
    calm = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_NONE;
    in_ch.byte_address = '0;
    in_ch.thread_id = '0;
    out_ch.ready = 1'b0;
  end

  // Watchdog: count cycles and bail out on a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Response side: check each transfer against the oldest prediction, then
  // pick ready for the next cycle, dropping it at random with a 12 percent chance.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.record_index);
    out_ch.ready <= rst_n && (calm || $urandom_range(0, 99) >= 12);
  end

  // Present one request and hold it until it transfers. An idle gap, if one
  // is drawn, drops valid first; otherwise valid stays high across items.
  task automatic send(mode_t mode, logic [47:0] addr, logic [2:0] tid);
    int gap;
    if (!calm && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.byte_address <= addr;
    in_ch.thread_id    <= tid;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(mode, addr, tid);
  endtask

  // Hold valid low until every predicted response has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Build a byte address from a line: random offset inside the line.
  function automatic logic [47:0] addr_of(logic [LW-1:0] line);
    return {line, 6'($urandom)};
  endfunction

  // Mostly a small pool of lines so that markers collide and alias; now and
  // then a fully random address to toggle the high bits.
  function automatic logic [47:0] pick_addr();
    logic [LW-1:0] line;
    if ($urandom_range(0, 99) < 8) return 48'({$urandom, $urandom});
    line = '0;
    line[MW-1:0] = MW'($urandom_range(0, 15));
    line[LW-1:MW] = (LW-MW)'($urandom_range(0, 3));
    return addr_of(line);
  endfunction

  function automatic mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 76) return MODE_WRITE;
    if (r < 88) return MODE_RELEASE;
    if (r < 96) return MODE_CLEAR;
    return MODE_NONE;
  endfunction

  function automatic logic [2:0] pick_tid();
    if ($urandom_range(0, 3) != 0) return 3'($urandom_range(0, 3));
    return 3'($urandom);
  endfunction

  initial begin
    logic [LW-1:0] a;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: new, same line, alias appended, alias found, conflict.
    a = 42'd5;
    send(MODE_WRITE, addr_of(a), 3'd0);
    send(MODE_WRITE, addr_of(a), 3'd0);
    send(MODE_WRITE, addr_of(a + 42'd1024), 3'd0);
    send(MODE_WRITE, addr_of(a + 42'd1024), 3'd0);
    send(MODE_WRITE, addr_of(a), 3'd1);
    send(MODE_WRITE, addr_of(a + 42'd2048), 3'd0);
    // Release frees the marker whoever owns it; then the other thread claims.
    send(MODE_RELEASE, addr_of(a), 3'd1);
    send(MODE_WRITE, addr_of(a), 3'd1);
    send(MODE_CLEAR, '0, 3'd0);
    send(MODE_CLEAR, '0, 3'd1);
    send(MODE_NONE, 48'hFFFF_FFFF_FFFF, 3'd7);
    send(MODE_WRITE, 48'hFFFF_FFFF_FFFF, 3'd7);
    send(MODE_WRITE, 48'h0, 3'd7);
    send(MODE_WRITE, 48'hFFFF_FFFF_FFC0, 3'd7);
    send(MODE_RELEASE, 48'hFFFF_FFFF_FFFF, 3'd6);
    send(MODE_CLEAR, '0, 3'd7);

    // Fill one thread's log past its end: log full, including a claim made
    // on a full log and a repeat write to a line claimed while full.
    for (int i = 0; i < LOG_DEPTH + 2; i++)
      send(MODE_WRITE, addr_of(42'(200 + i) | (42'd7 << MW)), 3'd5);
    send(MODE_WRITE, addr_of(42'd5), 3'd5);
    send(MODE_WRITE, addr_of(42'd900), 3'd5);
    send(MODE_WRITE, addr_of(42'd900), 3'd5);
    send(MODE_CLEAR, '0, 3'd5);
    // Stale claim left by the full log: same-thread hit past the log end.
    send(MODE_WRITE, addr_of(42'd900 + 42'd1024), 3'd5);
    send(MODE_CLEAR, '0, 3'd5);
    send(MODE_RELEASE, addr_of(42'd900), 3'd5);
    drain();

    // Random traffic; one stretch with no idling on either side.
    for (int n = 0; n < 960; n++) begin
      calm = (n >= 300 && n < 500);
      if (n == 700) drain();
      send(pick_mode(), pick_addr(), pick_tid());
    end
    calm = 0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
